/* sv/tlca_pkg.sv */
package tlca_pkg;

    localparam int MAX_NODES_DEF   = 1024;
    localparam int LIFT_LEVELS_DEF = 10;
    localparam int NODE_W          = 10;
    localparam int CFG_IDX_W       = 1;

    localparam logic CMD_ADD_EDGE = 1'b0;
    localparam logic CMD_LCA      = 1'b1;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_NODE  = 1'd1;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_RA,
        ST_ADD_WA,
        ST_ADD_RB,
        ST_ADD_WB,
        ST_INIT,
        ST_ROOT,
        ST_WTEST,
        ST_WPOP,
        ST_WEDGE,
        ST_WCHK,
        ST_WPUSH,
        ST_FILL_R1,
        ST_FILL_R2,
        ST_FILL_WR,
        ST_QD1,
        ST_QD2,
        ST_QD3,
        ST_UP,
        ST_UPW,
        ST_EQ,
        ST_LA,
        ST_LB,
        ST_LC,
        ST_DONE
    } tlca_state_t;

endpackage

/* sv/tree_lca_binary_lifting.sv */
// edge add: reads and writes the list head of each endpoint in turn, gives no result;
// a query with a bad node goes straight to the result. A query on a built table reads both
// depths, lifts the deeper node by the difference, then climbs, checking every level; its
// pace is set by the one ancestor read port. The first query after a change also runs the
// build: an init sweep of the nodes, a depth-first walk, then the fill of the upper levels
// reset: control cleared, then a pass over all MAX_NODES entries clears the adjacency heads
module tree_lca_binary_lifting import tlca_pkg::*; #(
    parameter int MAX_NODES   = MAX_NODES_DEF,
    parameter int LIFT_LEVELS = LIFT_LEVELS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [NODE_W-1:0]    cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_command,
    input  logic [NODE_W-1:0]    s_node_a,
    input  logic [NODE_W-1:0]    s_node_b,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [NODE_W-1:0]    m_ancestor,
    output logic                 m_status
);

    localparam int NW       = $clog2(MAX_NODES);
    localparam int EW       = NW + 1;
    localparam int EDGE_CAP = 2 * MAX_NODES;
    localparam int LW       = $clog2(LIFT_LEVELS);
    localparam int CW       = ((NW > NODE_W) ? NW : NODE_W) + 1;
    localparam int SPW      = NW + 1;
    localparam int TOP      = LIFT_LEVELS - 1;
    localparam int ANC_DEPTH = LIFT_LEVELS << NW;

    localparam logic [LW-1:0] TOP_K = LW'(TOP);

    tlca_state_t state_reg, state_next;

    logic [NODE_W-1:0] node_count_reg, root_node_reg;
    logic              built_reg;
    logic [EW-1:0]     total_reg;
    logic [NODE_W-1:0] a_reg, b_reg;
    logic [NW-1:0]     sweep_reg, cur_reg, t_reg, u_reg, v_reg, du_reg, diff_reg, au_reg;
    logic [EW-1:0]     e_reg;
    logic [SPW-1:0]    sp_reg;
    logic [LW-1:0]     k_reg;
    logic              m_valid_reg, m_status_reg;
    logic [NODE_W-1:0] m_ancestor_reg;
    logic [NODE_W-1:0] ans_reg;
    logic              err_reg;

    // memories
    logic [EW-1:0] head_mem [0:MAX_NODES-1];
    logic [EW-1:0] link_mem [0:EDGE_CAP-1];
    logic [NW-1:0] tgt_mem  [0:EDGE_CAP-1];
    logic [NW-1:0] depth_mem [0:MAX_NODES-1];
    logic          seen_mem [0:MAX_NODES-1];
    logic [NW-1:0] stkn_mem [0:MAX_NODES-1];
    logic [EW-1:0] stke_mem [0:MAX_NODES-1];
    logic [NW-1:0] anc_mem  [0:ANC_DEPTH-1];

    logic          head_we;  logic [NW-1:0] head_wa, head_ra; logic [EW-1:0] head_wd, head_rd;
    logic          edge_we;  logic [EW-1:0] edge_wa, edge_ra, link_wd, link_rd;
    logic [NW-1:0] tgt_wd, tgt_rd;
    logic          depth_we; logic [NW-1:0] depth_wa, depth_ra, depth_wd, depth_rd;
    logic          seen_we;  logic [NW-1:0] seen_wa, seen_ra; logic seen_wd, seen_rd;
    logic          stk_we;   logic [NW-1:0] stk_wa, stk_ra, stkn_wd, stkn_rd;
    logic [EW-1:0] stke_wd, stke_rd;
    logic          anc_we;   logic [LW+NW-1:0] anc_wa, anc_ra; logic [NW-1:0] anc_wd, anc_rd;

    // derived conditions
    logic [CW-1:0] cnt;
    logic          a_in, b_in, root_in, a_ep, b_ep, room, tgt_ok, up_cond;
    logic [NW-1:0] root_n, a_n, b_n;

    assign cnt = (CW'(node_count_reg) < CW'(MAX_NODES - 1)) ? CW'(node_count_reg)
                                                             : CW'(MAX_NODES - 1);
    assign a_in    = (s_node_a != '0) && (CW'(s_node_a) <= cnt);
    assign b_in    = (s_node_b != '0) && (CW'(s_node_b) <= cnt);
    assign root_in = (root_node_reg != '0) && (CW'(root_node_reg) <= cnt);
    assign a_ep    = (s_node_a != '0) && (CW'(s_node_a) < CW'(MAX_NODES));
    assign b_ep    = (s_node_b != '0) && (CW'(s_node_b) < CW'(MAX_NODES));
    assign room    = ((EW+1)'(total_reg) + (EW+1)'(2)) <= (EW+1)'(EDGE_CAP - 1);
    assign tgt_ok  = (tgt_rd != '0) && (CW'(tgt_rd) <= cnt) && (sp_reg < SPW'(MAX_NODES));
    assign root_n  = NW'(root_node_reg);
    assign a_n     = NW'(a_reg);
    assign b_n     = NW'(b_reg);
    // at the top level the jump repeats while the difference spans it
    assign up_cond = (k_reg == TOP_K) ? ((diff_reg >> TOP) != '0)
                                      : (((diff_reg >> k_reg) & NW'(1)) != '0);

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_ancestor = m_ancestor_reg;
    assign m_status   = m_status_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:   if (sweep_reg == NW'(MAX_NODES - 1)) state_next = ST_IDLE;
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_command == CMD_ADD_EDGE) begin
                        if (a_ep && b_ep && room) state_next = ST_ADD_RA;
                    end else if (!(a_in && b_in && root_in)) begin
                        state_next = ST_DONE;
                    end else if (!built_reg) begin
                        state_next = ST_INIT;
                    end else begin
                        state_next = ST_QD1;
                    end
                end
            end
            ST_ADD_RA:  state_next = ST_ADD_WA;
            ST_ADD_WA:  state_next = ST_ADD_RB;
            ST_ADD_RB:  state_next = ST_ADD_WB;
            ST_ADD_WB:  state_next = ST_IDLE;
            ST_INIT:    if (CW'(sweep_reg) == cnt) state_next = ST_ROOT;
            ST_ROOT:    state_next = ST_WPUSH;
            ST_WTEST: begin
                if (e_reg != '0)          state_next = ST_WEDGE;
                else if (sp_reg == SPW'(1)) state_next = ST_FILL_R1;
                else                      state_next = ST_WPOP;
            end
            ST_WPOP:    state_next = ST_WTEST;
            ST_WEDGE:   state_next = tgt_ok ? ST_WCHK : ST_WTEST;
            ST_WCHK:    state_next = seen_rd ? ST_WTEST : ST_WPUSH;
            ST_WPUSH:   state_next = ST_WTEST;
            ST_FILL_R1: state_next = ST_FILL_R2;
            ST_FILL_R2: state_next = ST_FILL_WR;
            ST_FILL_WR: begin
                if (CW'(sweep_reg) == cnt && k_reg == TOP_K) state_next = ST_QD1;
                else                                         state_next = ST_FILL_R1;
            end
            ST_QD1:     state_next = ST_QD2;
            ST_QD2:     state_next = ST_QD3;
            ST_QD3:     state_next = ST_UP;
            ST_UP: begin
                if (up_cond)             state_next = ST_UPW;
                else if (k_reg == '0)    state_next = ST_EQ;
            end
            ST_UPW:     state_next = ST_UP;
            ST_EQ:      state_next = (u_reg == v_reg) ? ST_DONE : ST_LA;
            ST_LA:      state_next = ST_LB;
            ST_LB:      state_next = ST_LC;
            ST_LC: begin
                if (au_reg == anc_rd && k_reg == '0) state_next = ST_DONE;
                else                                 state_next = ST_LA;
            end
            ST_DONE:    if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default:    state_next = ST_CLEAR;
        endcase
    end

    // memory controls
    always_comb begin
        head_we = 1'b0; head_wa = a_n; head_wd = '0; head_ra = a_n;
        edge_we = 1'b0; edge_wa = '0; edge_ra = e_reg; link_wd = head_rd; tgt_wd = b_n;
        depth_we = 1'b0; depth_wa = sweep_reg; depth_wd = '0; depth_ra = cur_reg;
        seen_we = 1'b0; seen_wa = sweep_reg; seen_wd = 1'b0; seen_ra = tgt_rd;
        stk_we = 1'b0; stk_wa = NW'(sp_reg - SPW'(1)); stkn_wd = cur_reg; stke_wd = e_reg;
        stk_ra = NW'(sp_reg - SPW'(2));
        anc_we = 1'b0; anc_wa = {LW'(0), sweep_reg}; anc_wd = root_n;
        anc_ra = {k_reg, u_reg};
        case (state_reg)
            ST_CLEAR: begin
                head_we = 1'b1; head_wa = sweep_reg; head_wd = '0;
            end
            ST_ADD_RA: head_ra = a_n;
            ST_ADD_WA: begin
                head_we = 1'b1; head_wa = a_n; head_wd = total_reg + EW'(1);
                edge_we = 1'b1; edge_wa = total_reg + EW'(1); tgt_wd = b_n;
            end
            ST_ADD_RB: head_ra = b_n;
            ST_ADD_WB: begin
                head_we = 1'b1; head_wa = b_n; head_wd = total_reg + EW'(2);
                edge_we = 1'b1; edge_wa = total_reg + EW'(2); tgt_wd = a_n;
            end
            ST_INIT: begin
                depth_we = 1'b1; depth_wd = (sweep_reg == root_n) ? NW'(0) : NW'(1);
                seen_we  = 1'b1; seen_wd  = (sweep_reg == root_n);
                anc_we   = 1'b1;
            end
            ST_ROOT:  head_ra = root_n;
            ST_WTEST: edge_ra = e_reg;
            ST_WEDGE: begin
                seen_ra = tgt_rd; depth_ra = cur_reg;
            end
            ST_WCHK: begin
                if (!seen_rd) begin
                    stk_we = 1'b1;
                    seen_we = 1'b1; seen_wa = t_reg; seen_wd = 1'b1;
                    depth_we = 1'b1; depth_wa = t_reg; depth_wd = depth_rd + NW'(1);
                    anc_we = 1'b1; anc_wa = {LW'(0), t_reg}; anc_wd = cur_reg;
                end
                head_ra = t_reg;
            end
            ST_FILL_R1: anc_ra = {k_reg - LW'(1), sweep_reg};
            ST_FILL_R2: anc_ra = {k_reg - LW'(1), anc_rd};
            ST_FILL_WR: begin
                anc_we = 1'b1; anc_wa = {k_reg, sweep_reg}; anc_wd = anc_rd;
            end
            ST_QD1: depth_ra = a_n;
            ST_QD2: depth_ra = b_n;
            ST_UP:  anc_ra = {k_reg, u_reg};
            ST_LA:  anc_ra = {k_reg, u_reg};
            ST_LB:  anc_ra = {k_reg, v_reg};
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (head_we) head_mem[head_wa] <= head_wd;
        head_rd <= head_mem[head_ra];
    end

    always_ff @(posedge aclk) begin
        if (edge_we) begin
            link_mem[edge_wa] <= link_wd;
            tgt_mem[edge_wa]  <= tgt_wd;
        end
        link_rd <= link_mem[edge_ra];
        tgt_rd  <= tgt_mem[edge_ra];
    end

    always_ff @(posedge aclk) begin
        if (depth_we) depth_mem[depth_wa] <= depth_wd;
        depth_rd <= depth_mem[depth_ra];
    end

    always_ff @(posedge aclk) begin
        if (seen_we) seen_mem[seen_wa] <= seen_wd;
        seen_rd <= seen_mem[seen_ra];
    end

    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stkn_mem[stk_wa] <= stkn_wd;
            stke_mem[stk_wa] <= stke_wd;
        end
        stkn_rd <= stkn_mem[stk_ra];
        stke_rd <= stke_mem[stk_ra];
    end

    always_ff @(posedge aclk) begin
        if (anc_we) anc_mem[anc_wa] <= anc_wd;
        anc_rd <= anc_mem[anc_ra];
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            node_count_reg <= NODE_W'(1);
            root_node_reg  <= NODE_W'(1);
            built_reg      <= 1'b0;
            total_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_NODE_COUNT: node_count_reg <= cfg_wdata;
                    CFG_ROOT_NODE:  root_node_reg  <= cfg_wdata;
                    default: ;
                endcase
                built_reg <= 1'b0;
            end
            if (state_reg == ST_ADD_WB) begin
                total_reg <= total_reg + EW'(2);
                built_reg <= 1'b0;
            end
            if (state_reg == ST_FILL_WR && CW'(sweep_reg) == cnt && k_reg == TOP_K)
                built_reg <= 1'b1;
            if (m_valid_reg && m_ready)
                m_valid_reg <= 1'b0;
            if (state_reg == ST_DONE && (!m_valid_reg || m_ready))
                m_valid_reg <= 1'b1;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_CLEAR: sweep_reg <= sweep_reg + NW'(1);
            ST_IDLE: begin
                sweep_reg <= NW'(1);
                a_reg     <= s_node_a;
                b_reg     <= s_node_b;
                err_reg   <= STATUS_ERR;
                ans_reg   <= '0;
            end
            ST_INIT: sweep_reg <= sweep_reg + NW'(1);
            ST_ROOT: begin
                cur_reg <= root_n;
                sp_reg  <= '0;
            end
            ST_WTEST: begin
                if (e_reg == '0) begin
                    sp_reg    <= sp_reg - SPW'(1);
                    k_reg     <= LW'(1);
                    sweep_reg <= NW'(1);
                end
            end
            ST_WPOP: begin
                cur_reg <= stkn_rd;
                e_reg   <= stke_rd;
            end
            ST_WEDGE: begin
                e_reg <= link_rd;
                t_reg <= tgt_rd;
            end
            ST_WCHK: if (!seen_rd) cur_reg <= t_reg;
            ST_WPUSH: begin
                e_reg  <= head_rd;
                sp_reg <= sp_reg + SPW'(1);
            end
            ST_FILL_WR: begin
                if (CW'(sweep_reg) == cnt) begin
                    sweep_reg <= NW'(1);
                    k_reg     <= k_reg + LW'(1);
                end else begin
                    sweep_reg <= sweep_reg + NW'(1);
                end
            end
            ST_QD2: du_reg <= depth_rd;
            ST_QD3: begin
                if (du_reg < depth_rd) begin
                    u_reg <= b_n; v_reg <= a_n; diff_reg <= depth_rd - du_reg;
                end else begin
                    u_reg <= a_n; v_reg <= b_n; diff_reg <= du_reg - depth_rd;
                end
                k_reg <= TOP_K;
            end
            ST_UP: if (!up_cond && k_reg != '0) k_reg <= k_reg - LW'(1);
            ST_UPW: begin
                u_reg    <= anc_rd;
                diff_reg <= diff_reg - (NW'(1) << k_reg);
            end
            ST_EQ: begin
                k_reg <= TOP_K;
                if (u_reg == v_reg) begin
                    ans_reg <= NODE_W'(u_reg);
                    err_reg <= STATUS_OK;
                end
            end
            ST_LB: au_reg <= anc_rd;
            ST_LC: begin
                if (au_reg != anc_rd) begin
                    u_reg <= au_reg;
                    v_reg <= anc_rd;
                    // top level repeats while it differs; level zero rechecks the parents
                    if (k_reg != TOP_K && k_reg != '0) k_reg <= k_reg - LW'(1);
                end else if (k_reg == '0) begin
                    ans_reg <= NODE_W'(au_reg);
                    err_reg <= STATUS_OK;
                end else begin
                    k_reg <= k_reg - LW'(1);
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_ancestor_reg <= ans_reg;
                    m_status_reg   <= err_reg;
                end
            end
            default: ;
        endcase
        if (!aresetn) sweep_reg <= '0;
    end

endmodule
